// ===== design/dspdm_pkg.sv =====
package dspdm_pkg;

   localparam int MAX_OVERSAMPLE = 16;
   localparam int WORD_BITS      = 32;
   localparam int INTEG_W        = 32;
   localparam int SAMPLE_W       = 16;
   localparam int PDM_W          = 32;
   localparam int OSF_W          = 5;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 5;
   localparam int BIT_W          = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int CNT_W          = $clog2(MAX_OVERSAMPLE + 1);

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_FORMAT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OVERSAMPLE_FACTOR = 1'd1;

   localparam logic FMT_S16 = 1'b0;
   localparam logic FMT_U8  = 1'b1;

   localparam logic [INTEG_W-1:0] FB_STEP = INTEG_W'(32'h0001_0000);
   localparam logic [INTEG_W-1:0] LFSR_RESET = '1;

   typedef enum logic [1:0] {
      FB_NONE = 2'd0,
      FB_POS  = 2'd1,
      FB_NEG  = 2'd2
   } fb_level_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DITHER = 4'b0010,
      ST_RUN    = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   typedef struct packed {
      logic lfsr_step;
      logic bit_step;
   } loop_ctl_type;

endpackage

// ===== design/dspdm_loop.sv =====
module dspdm_loop (
   input  logic                                clock,
   input  logic                                reset,
   input  dspdm_pkg::loop_ctl_type             ctl,
   input  logic [dspdm_pkg::INTEG_W-1:0]       sample_x,
   output logic [dspdm_pkg::WORD_BITS-1:0]     word
);

   logic [dspdm_pkg::INTEG_W-1:0]   integ1_ff, integ1_in;
   logic [dspdm_pkg::INTEG_W-1:0]   integ2_ff, integ2_in;
   logic [dspdm_pkg::INTEG_W-1:0]   lfsr_ff, lfsr_in;
   logic [dspdm_pkg::INTEG_W-1:0]   os_ff, os_in;
   logic [dspdm_pkg::WORD_BITS-1:0] word_ff, word_in;
   dspdm_pkg::fb_level_type         fb_ff, fb_in;
   logic [dspdm_pkg::INTEG_W-1:0]   fb_val;
   logic [dspdm_pkg::INTEG_W-1:0]   lfsr_next;

   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[10] ^ lfsr_ff[30] ^ lfsr_ff[31],
                       lfsr_ff[dspdm_pkg::INTEG_W-1:1]};

   always_comb begin
      case (fb_ff)
         dspdm_pkg::FB_POS: fb_val = dspdm_pkg::FB_STEP;
         dspdm_pkg::FB_NEG: fb_val = -dspdm_pkg::FB_STEP;
         default:           fb_val = '0;
      endcase
   end

   always_comb begin
      integ1_in = integ1_ff;
      integ2_in = integ2_ff;
      fb_in     = fb_ff;
      word_in   = word_ff;
      lfsr_in   = lfsr_ff;
      os_in     = os_ff;
      if (ctl.lfsr_step) begin
         lfsr_in = lfsr_next;
         os_in   = sample_x + {{(dspdm_pkg::INTEG_W-4){1'b0}}, lfsr_next[3:0]};
      end
      if (ctl.bit_step) begin
         integ1_in = integ1_ff + os_ff - fb_val;
         integ2_in = integ2_ff + integ1_in - fb_val;
         word_in   = {~integ2_in[dspdm_pkg::INTEG_W-1],
                      word_ff[dspdm_pkg::WORD_BITS-1:1]};
         fb_in     = integ2_in[dspdm_pkg::INTEG_W-1] ? dspdm_pkg::FB_NEG
                                                     : dspdm_pkg::FB_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ1_ff <= '0;
         integ2_ff <= '0;
         fb_ff     <= dspdm_pkg::FB_NONE;
         lfsr_ff   <= dspdm_pkg::LFSR_RESET;
      end else begin
         integ1_ff <= integ1_in;
         integ2_ff <= integ2_in;
         fb_ff     <= fb_in;
         lfsr_ff   <= lfsr_in;
      end
      os_ff   <= os_in;
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== design/dithered_delta_sigma_pdm_modulator.sv =====
// Dithered second-order delta-sigma PDM modulator, one modulator bit per clock
// in the run state; the emit state waits while the output is stalled. Each
// sample makes N words, N = clamped oversample factor, on the single integrator
// datapath; a new sample is taken only after the last word of the one before.
// Synchronous reset clears integrators and feedback, sets the LFSR to all ones,
// format to signed 16-bit and oversample factor to 1.
module dithered_delta_sigma_pdm_modulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dspdm_pkg::SAMPLE_W-1:0]       req_tdata,   // sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dspdm_pkg::PDM_W-1:0]          rsp_tdata,   // pdm_word
   output logic                                 rsp_tlast,   // last_word
   input  logic                                 csr_we,
   input  logic [dspdm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dspdm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dspdm_pkg::state_type             state_ff, state_in;
   logic                             fmt_ff, fmt_in;
   logic [dspdm_pkg::OSF_W-1:0]      osf_ff, osf_in;
   logic [dspdm_pkg::INTEG_W-1:0]    x_ff, x_in;
   logic [dspdm_pkg::CNT_W-1:0]      rem_ff, rem_in;
   logic [dspdm_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dspdm_pkg::PDM_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [dspdm_pkg::CNT_W-1:0]      n_words;
   logic [dspdm_pkg::INTEG_W-1:0]    x_conv;
   logic [dspdm_pkg::WORD_BITS-1:0]  word;
   dspdm_pkg::loop_ctl_type          ctl;
   logic                             accept;
   logic                             load;

   dspdm_loop u_loop (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample_x (x_ff),
      .word     (word)
   );

   assign req_tready = (state_ff == dspdm_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign load       = (state_ff == dspdm_pkg::ST_EMIT) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      if (fmt_ff == dspdm_pkg::FMT_U8)
         x_conv = {{(dspdm_pkg::INTEG_W-16){~req_tdata[7]}}, ~req_tdata[7],
                   req_tdata[6:0], 8'h00};
      else
         x_conv = {{(dspdm_pkg::INTEG_W-16){req_tdata[15]}}, req_tdata[15:0]};
   end

   always_comb begin
      if (osf_ff == '0)
         n_words = dspdm_pkg::CNT_W'(1);
      else if (32'(osf_ff) > 32'(dspdm_pkg::MAX_OVERSAMPLE))
         n_words = dspdm_pkg::CNT_W'(dspdm_pkg::MAX_OVERSAMPLE);
      else
         n_words = dspdm_pkg::CNT_W'(osf_ff);
   end

   always_comb begin
      fmt_in = fmt_ff;
      osf_in = osf_ff;
      if (csr_we) begin
         case (csr_index)
            dspdm_pkg::REG_SAMPLE_FORMAT:     fmt_in = csr_wdata[0];
            dspdm_pkg::REG_OVERSAMPLE_FACTOR: osf_in = dspdm_pkg::OSF_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      ctl.lfsr_step = 1'b0;
      ctl.bit_step  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         dspdm_pkg::ST_IDLE: begin
            if (accept) begin
               x_in     = x_conv;
               rem_in   = n_words;
               state_in = dspdm_pkg::ST_DITHER;
            end
         end
         dspdm_pkg::ST_DITHER: begin
            ctl.lfsr_step = 1'b1;
            bit_in        = '0;
            state_in      = dspdm_pkg::ST_RUN;
         end
         dspdm_pkg::ST_RUN: begin
            ctl.bit_step = 1'b1;
            bit_in       = bit_ff + dspdm_pkg::BIT_W'(1);
            if (bit_ff == dspdm_pkg::BIT_W'(dspdm_pkg::WORD_BITS - 1))
               state_in = dspdm_pkg::ST_EMIT;
         end
         dspdm_pkg::ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dspdm_pkg::PDM_W'(word);
               rsp_last_in  = (rem_ff == dspdm_pkg::CNT_W'(1));
               rem_in       = rem_ff - dspdm_pkg::CNT_W'(1);
               state_in     = (rem_ff == dspdm_pkg::CNT_W'(1)) ? dspdm_pkg::ST_IDLE
                                                               : dspdm_pkg::ST_DITHER;
            end
         end
         default: state_in = dspdm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dspdm_pkg::ST_IDLE;
         fmt_ff       <= dspdm_pkg::FMT_S16;
         osf_ff       <= dspdm_pkg::OSF_W'(1);
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fmt_ff       <= fmt_in;
         osf_ff       <= osf_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         bit_ff       <= bit_in;
      end
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == dspdm_pkg::ST_DITHER) && (rem_ff != '0) &&
                 (32'(rem_ff) <= 32'(dspdm_pkg::MAX_OVERSAMPLE)))
      else $error("bad word count after sample accept");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dspdm_pkg::ST_RUN) &&
      (bit_ff == dspdm_pkg::BIT_W'(dspdm_pkg::WORD_BITS - 1))
      |=> (state_ff == dspdm_pkg::ST_EMIT))
      else $error("bit loop did not end on last bit");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      load && (rem_ff == dspdm_pkg::CNT_W'(1))
      |=> (state_ff == dspdm_pkg::ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("last word not flagged or sequencer not idle");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dspdm_pkg::ST_EMIT) && rsp_valid_ff && !rsp_tready
      |=> (state_ff == dspdm_pkg::ST_EMIT))
      else $error("word dropped while output stalled");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic [dspdm_pkg::PDM_W-1:0] bits;
      logic                        last;
   } pdm_word_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [dspdm_pkg::SAMPLE_W-1:0]     req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [dspdm_pkg::PDM_W-1:0]        rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_we;
   logic [dspdm_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [dspdm_pkg::CSR_DATA_W-1:0]   csr_wdata;

   dithered_delta_sigma_pdm_modulator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // modulator state mirror
   logic [dspdm_pkg::INTEG_W-1:0]    stage1_acc;
   logic [dspdm_pkg::INTEG_W-1:0]    stage2_acc;
   dspdm_pkg::fb_level_type          fb_state;
   logic [31:0]                      dither_reg;
   logic                             fmt_sel;
   logic [dspdm_pkg::OSF_W-1:0]      os_ratio;

   pdm_word_type          pdm_expect[$];
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    error_count;
   int                    missing_count;
   int                    samples_sent;
   int                    words_checked;
   int                    cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic modulate_sample(input logic [dspdm_pkg::SAMPLE_W-1:0] s);
      logic [31:0]                   x;
      logic [31:0]                   t;
      logic [31:0]                   os;
      logic [31:0]                   fbv;
      logic [dspdm_pkg::PDM_W-1:0]   word;
      logic                          nb;
      int                            n;
      pdm_word_type                  e;
      if (fmt_sel == dspdm_pkg::FMT_U8) begin
         t = {24'd0, s[7:0]} - 32'd128;
         x = t << 8;
      end else begin
         x = {{16{s[15]}}, s};
      end
      if (os_ratio == 0)
         n = 1;
      else if (os_ratio > dspdm_pkg::MAX_OVERSAMPLE)
         n = dspdm_pkg::MAX_OVERSAMPLE;
      else
         n = int'(os_ratio);
      for (int w = 0; w < n; w++) begin
         nb = dither_reg[0] ^ dither_reg[10] ^ dither_reg[30] ^ dither_reg[31];
         dither_reg = {nb, dither_reg[31:1]};
         os = x + {28'd0, dither_reg[3:0]};
         word = '0;
         for (int b = 0; b < dspdm_pkg::WORD_BITS; b++) begin
            if (fb_state == dspdm_pkg::FB_POS)
               fbv = dspdm_pkg::FB_STEP;
            else if (fb_state == dspdm_pkg::FB_NEG)
               fbv = -dspdm_pkg::FB_STEP;
            else
               fbv = '0;
            stage1_acc = stage1_acc + os - fbv;
            stage2_acc = stage2_acc + stage1_acc - fbv;
            word = word >> 1;
            if (!stage2_acc[31]) begin
               word[dspdm_pkg::PDM_W-1] = 1'b1;
               fb_state = dspdm_pkg::FB_POS;
            end else begin
               fb_state = dspdm_pkg::FB_NEG;
            end
         end
         e.bits = word;
         e.last = (w + 1 == n);
         pdm_expect.push_back(e);
      end
   endtask

   // called at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_sample(input logic [dspdm_pkg::SAMPLE_W-1:0] s);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      do @(posedge clock); while (!req_tready);
      modulate_sample(s);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid = 1'b0;
      while (pdm_expect.size() != 0) @(negedge clock);
      repeat (dspdm_pkg::WORD_BITS + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [dspdm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dspdm_pkg::CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      if (idx == dspdm_pkg::REG_SAMPLE_FORMAT)
         fmt_sel = val[0];
      else if (idx == dspdm_pkg::REG_OVERSAMPLE_FACTOR)
         os_ratio = val;
   endtask

   task automatic test_signed_extremes();
      send_sample(16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      wait_drain();
   endtask

   task automatic test_factor_limits();
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd0);
      send_sample(16'h1234);
      wait_drain();
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd31);
      send_sample(16'h8000);
      wait_drain();
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd17);
      send_sample(16'hC000);
      wait_drain();
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd16);
      send_sample(16'h7FFF);
      wait_drain();
   endtask

   task automatic test_unsigned_format();
      write_reg(dspdm_pkg::REG_SAMPLE_FORMAT, dspdm_pkg::CSR_DATA_W'(dspdm_pkg::FMT_U8));
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd3);
      send_sample(16'h0000);
      send_sample(16'h00FF);
      send_sample(16'hFF80);
      send_sample(16'hAB7F);
      send_sample(16'h0080);
      send_sample(16'hFF00);
      wait_drain();
      write_reg(dspdm_pkg::REG_SAMPLE_FORMAT, dspdm_pkg::CSR_DATA_W'(dspdm_pkg::FMT_S16));
      write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, 5'd1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      logic [dspdm_pkg::SAMPLE_W-1:0]   s;
      logic [dspdm_pkg::CSR_DATA_W-1:0] f;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int grp = 0; grp < 4; grp++) begin
         f = ($urandom_range(9) == 0) ? dspdm_pkg::CSR_DATA_W'($urandom_range(31))
                                      : dspdm_pkg::CSR_DATA_W'($urandom_range(1, 5));
         write_reg(dspdm_pkg::REG_SAMPLE_FORMAT,
                   dspdm_pkg::CSR_DATA_W'($urandom_range(1)));
         write_reg(dspdm_pkg::REG_OVERSAMPLE_FACTOR, f);
         for (int k = 0; k < 10; k++) begin
            case ($urandom_range(7))
               0: s = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
               1: s = ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
               default: s = dspdm_pkg::SAMPLE_W'($urandom_range(65535));
            endcase
            send_sample(s);
         end
         wait_drain();
      end
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      pdm_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (pdm_expect.size() == 0) begin
            if (error_count < 10)
               $display("unexpected word %h last %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            e = pdm_expect.pop_front();
            if (rsp_tdata !== e.bits || rsp_tlast !== e.last) begin
               if (error_count < 10)
                  $display("word mismatch: pdm exp %h got %h, last exp %b got %b",
                           e.bits, rsp_tdata, e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[dithered_delta_sigma_pdm_modulator] ERROR");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      missing_count  = 0;
      samples_sent   = 0;
      stage1_acc     = '0;
      stage2_acc     = '0;
      fb_state       = dspdm_pkg::FB_NONE;
      dither_reg     = dspdm_pkg::LFSR_RESET;
      fmt_sel        = dspdm_pkg::FMT_S16;
      os_ratio       = dspdm_pkg::OSF_W'(1);
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_signed_extremes();
      test_factor_limits();
      test_unsigned_format();
      test_random_traffic(0, 0);
      test_random_traffic(62, 0);
      test_random_traffic(0, 62);
      test_random_traffic(7, 7);

      if (pdm_expect.size() != 0) begin
         $display("%0d words never arrived", pdm_expect.size());
         missing_count = pdm_expect.size();
      end
      $display("ran %0d samples, checked %0d PDM words, %0d mismatches",
               samples_sent, words_checked, error_count + missing_count);
      $display("both formats, factors 0..31 incl. clamping, four handshake pressure mixes");
      if (error_count + missing_count == 0)
         $display("[dithered_delta_sigma_pdm_modulator] OK");
      else
         $display("[dithered_delta_sigma_pdm_modulator] ERROR");
      $finish;
   end

endmodule
